[src/pgss_pkg.sv]
package pgss_pkg;

    localparam int TableDepth = 96;
    localparam int IdxW       = 7;
    localparam int DivW       = 9;
    localparam int StepW      = 4;

    localparam logic [7:0] FirstCode = 8'd32;
    localparam logic [7:0] LastCode  = 8'd127;
    localparam logic [7:0] SubstCode = 8'd63;
    localparam logic [7:0] SpaceCode = 8'd32;
    localparam logic [7:0] EndCode   = 8'd0;
    localparam logic [DivW-1:0] RowTexels = 9'd256;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_START = 2'd1,
        REQ_CHAR  = 2'd2,
        REQ_NONE  = 2'd3
    } pgss_req_t;

    typedef enum logic [1:0] {
        REG_GLYPH_W = 2'd0,
        REG_GLYPH_H = 2'd1,
        REG_ATLAS_X = 2'd2,
        REG_ATLAS_Y = 2'd3
    } pgss_reg_t;

    typedef enum logic {
        KIND_SPRITE = 1'b0,
        KIND_PAGE   = 1'b1
    } pgss_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } pgss_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pgss_div_stat_t;

endpackage

[src/pgss_div.sv]
module pgss_div
    import pgss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DivW-1:0]     dividend,
    input  logic [DivW-1:0]     divisor,
    output pgss_div_stat_t      stat,
    output logic [DivW-1:0]     quotient,
    output logic [DivW-1:0]     remainder
);

    logic [DivW-1:0]  rem_reg, rem_next;
    logic [DivW-1:0]  quo_reg, quo_next;
    logic [DivW-1:0]  dvs_reg;
    logic [StepW-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DivW:0]    trial;
    logic [DivW:0]    diff;
    logic             ge;

    // one quotient bit per cycle, restoring; remainder stays below the divisor so
    // the top bit of the difference is the borrow
    always_comb begin
        trial    = {rem_reg, quo_reg[DivW-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = !diff[DivW];
        rem_next = ge ? diff[DivW-1:0] : trial[DivW-1:0];
        quo_next = {quo_reg[DivW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= StepW'(DivW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == StepW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[src/proportional_glyph_sprite_setup_top.sv]
// Glyph sprite setup for one proportional font atlas. Each input beat carries a request
// in s_tuser: an advance-width table write, a string start (cursor x, line y, tint) or one
// character byte. Table writes and starts give no result. A space reads its advance and
// moves the cursor, with no result. A zero byte gives a texture page record. Any other
// glyph gives one sprite record, and the next beat is taken once that record is in the
// output register. The advance table is a 96 x 8 synchronous memory with a registered
// read, and the row and column of the glyph come from a bit-serial divider. Writing
// glyph_width makes the same divider recompute the glyphs per row, which holds s_tready
// low until the new value is in place (a width of zero sets it directly, without the
// divider). A record that finds the output register still full waits for m_tready,
// and the input stays closed meanwhile. The result sits in an output register, so table
// writes and starts are taken while a record waits on m_tready.
module proportional_glyph_sprite_setup_top
    import pgss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // table_index, width_value, char_code, start_x, start_y, tint_r, tint_g, tint_b
    input  logic [79:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // screen_x, screen_y, sprite_w, sprite_h, tex_u, tex_v, page_x, page_y,
    // out_r, out_g, out_b
    output logic [95:0] m_tdata,
    // record_kind
    output logic        m_tuser,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata
);

    // input beat fields
    logic [6:0]  in_table_index;
    logic [7:0]  in_width_value;
    logic [7:0]  in_char_code;
    logic [15:0] in_start_x;
    logic [15:0] in_start_y;
    logic [7:0]  in_tint_r, in_tint_g, in_tint_b;
    pgss_req_t   in_req;

    assign in_table_index = s_tdata[6:0];
    assign in_width_value = s_tdata[14:7];
    assign in_char_code   = s_tdata[22:15];
    assign in_start_x     = s_tdata[38:23];
    assign in_start_y     = s_tdata[54:39];
    assign in_tint_r      = s_tdata[62:55];
    assign in_tint_g      = s_tdata[70:63];
    assign in_tint_b      = s_tdata[78:71];
    assign in_req         = pgss_req_t'(s_tuser);

    // configuration registers
    logic [7:0] glyph_w_reg, glyph_h_reg;
    logic [9:0] atlas_x_reg;
    logic [8:0] atlas_y_reg;
    logic       rate_dirty_reg;

    // string state
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] line_y_reg;
    logic [7:0]  tint_r_reg, tint_g_reg, tint_b_reg;
    logic [DivW-1:0] per_row_reg;

    // glyph work registers
    logic [IdxW-1:0] idx_reg;
    logic [7:0]      adv_reg;
    logic [6:0]      row_reg, col_reg;
    logic [7:0]      tex_u_reg, tex_v_reg, sprite_w_reg;
    logic            is_page_reg;

    // output register
    logic        m_valid_reg;
    logic [95:0] m_data_reg;
    logic        m_kind_reg;
    logic        out_free;

    pgss_state_t state_reg, state_next;

    logic       accept;
    logic [7:0] mapped_code;
    logic [IdxW-1:0] mapped_idx;

    // advance table, one read port with registered data
    logic [7:0]      adv_mem [TableDepth];
    logic [7:0]      adv_rd_reg;

    // divider hookup
    logic            div_start;
    logic [DivW-1:0] div_dividend, div_divisor;
    logic [DivW-1:0] div_quo, div_rem;
    pgss_div_stat_t  div_stat;

    logic [14:0] u_prod, v_prod;
    logic [7:0]  sprite_w_calc;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // codes outside the printable range show as a question mark
    assign mapped_code = (in_char_code < FirstCode || in_char_code > LastCode)
                         ? SubstCode : in_char_code;
    assign mapped_idx  = IdxW'(mapped_code - FirstCode);

    // config writes are to come only while the block is idle; the block itself does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_w_reg    <= 8'd8;
            glyph_h_reg    <= 8'd8;
            atlas_x_reg    <= '0;
            atlas_y_reg    <= '0;
            rate_dirty_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (pgss_reg_t'(cfg_index))
                    REG_GLYPH_W: glyph_w_reg <= cfg_wdata[7:0];
                    REG_GLYPH_H: glyph_h_reg <= cfg_wdata[7:0];
                    REG_ATLAS_X: atlas_x_reg <= cfg_wdata;
                    REG_ATLAS_Y: atlas_y_reg <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
            // a new glyph width marks glyphs-per-row stale, a later write wins over a clear
            if (cfg_wr_en && pgss_reg_t'(cfg_index) == REG_GLYPH_W) begin
                rate_dirty_reg <= 1'b1;
            end else if (state_reg == ST_IDLE && rate_dirty_reg) begin
                rate_dirty_reg <= 1'b0;
            end
        end
    end

    // table memory: writes from table beats; the read is not gated and addresses the input character's entry
    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_WRITE && in_table_index < IdxW'(TableDepth)) begin
            adv_mem[in_table_index] <= in_width_value;
        end
        adv_rd_reg <= adv_mem[mapped_idx];
    end

    // glyphs per row is 256 / glyph width; width zero means a full 256-wide row
    // a character that is neither a space nor a zero byte goes on to the row and column division
    assign div_start    = (state_reg == ST_IDLE && rate_dirty_reg && glyph_w_reg != 8'd0)
                       || (state_reg == ST_READ && idx_reg != IdxW'(0));
    assign div_dividend = (state_reg == ST_IDLE) ? RowTexels : DivW'(idx_reg);
    assign div_divisor  = (state_reg == ST_IDLE) ? DivW'(glyph_w_reg) : per_row_reg;

    pgss_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // control: one item at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = !rate_dirty_reg;
                if (rate_dirty_reg) begin
                    if (glyph_w_reg != 8'd0) begin
                        state_next = ST_RATE;
                    end
                end else if (s_tvalid && in_req == REQ_CHAR) begin
                    state_next = (in_char_code == EndCode) ? ST_EMIT : ST_READ;
                end
            end
            ST_RATE: begin
                if (div_stat.done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                state_next = (idx_reg == IdxW'(0)) ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // cursor moves by the advance after a space or after a glyph is sent
    always_comb begin
        cursor_x_next = cursor_x_reg;
        if (accept && in_req == REQ_START) begin
            cursor_x_next = in_start_x;
        end else if (state_reg == ST_READ && idx_reg == IdxW'(0)) begin
            cursor_x_next = cursor_x_reg + {8'd0, adv_rd_reg};
        end else if (state_reg == ST_EMIT && out_free && !is_page_reg) begin
            cursor_x_next = cursor_x_reg + {8'd0, adv_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            line_y_reg   <= '0;
            tint_r_reg   <= '0;
            tint_g_reg   <= '0;
            tint_b_reg   <= '0;
            per_row_reg  <= DivW'(32);
        end else begin
            cursor_x_reg <= cursor_x_next;
            if (accept && in_req == REQ_START) begin
                line_y_reg <= in_start_y;
                tint_r_reg <= in_tint_r;
                tint_g_reg <= in_tint_g;
                tint_b_reg <= in_tint_b;
            end
            if (state_reg == ST_IDLE && rate_dirty_reg && glyph_w_reg == 8'd0) begin
                per_row_reg <= RowTexels;
            end else if (state_reg == ST_RATE && div_stat.done) begin
                per_row_reg <= div_quo;
            end
        end
    end

    // texel offsets: column times width, base v plus row times height
    assign u_prod        = col_reg * glyph_w_reg;
    assign v_prod        = row_reg * glyph_h_reg;
    assign sprite_w_calc = (adv_reg != 8'd0 && adv_reg < glyph_w_reg) ? adv_reg : glyph_w_reg;

    always_ff @(posedge aclk) begin
        if (accept && in_req == REQ_CHAR) begin
            idx_reg     <= mapped_idx;
            is_page_reg <= (in_char_code == EndCode);
        end
        if (state_reg == ST_READ) begin
            adv_reg <= adv_rd_reg;
        end
        if (state_reg == ST_DIV && div_stat.done) begin
            row_reg <= div_quo[6:0];
            col_reg <= div_rem[6:0];
        end
        if (state_reg == ST_MUL) begin
            tex_u_reg    <= u_prod[7:0];
            tex_v_reg    <= atlas_y_reg[7:0] + v_prod[7:0];
            sprite_w_reg <= sprite_w_calc;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg[95:93] <= '0;
            m_data_reg[67:64] <= atlas_x_reg[9:6];
            m_data_reg[68]    <= atlas_y_reg[8];
            if (is_page_reg) begin
                m_kind_reg        <= KIND_PAGE;
                m_data_reg[63:0]  <= '0;
                m_data_reg[92:69] <= '0;
            end else begin
                m_kind_reg        <= KIND_SPRITE;
                m_data_reg[15:0]  <= cursor_x_reg;
                m_data_reg[31:16] <= line_y_reg;
                m_data_reg[39:32] <= sprite_w_reg;
                m_data_reg[47:40] <= glyph_h_reg;
                m_data_reg[55:48] <= tex_u_reg;
                m_data_reg[63:56] <= tex_v_reg;
                m_data_reg[76:69] <= tint_r_reg;
                m_data_reg[84:77] <= tint_g_reg;
                m_data_reg[92:85] <= tint_b_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

[src/pgss_checker.sv]
module pgss_checker
    import pgss_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_wr_en,
    input logic [1:0]  cfg_index
);

    // a stalled record holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("record changed while stalled");

    // a character beat keeps the block busy for at least the next cycle
    a_char_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_CHAR |=> !s_tready)
        else $error("input taken right after a character beat");

    // new glyph width stalls input while glyphs per row is recomputed
    a_rate_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == REG_GLYPH_W |=> !s_tready)
        else $error("input taken during glyphs-per-row update");

    // page record carries only the page fields
    a_page_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAGE |-> m_tdata[63:0] == '0 && m_tdata[92:69] == '0)
        else $error("page record with nonzero sprite fields");

endmodule

bind proportional_glyph_sprite_setup_top pgss_checker u_pgss_checker (.*);
